>>> src/weighted_sample_selector_core_assert.svh
// Assertion macros used by the port-level checker.
`ifndef WEIGHTED_SAMPLE_SELECTOR_CORE_ASSERT_SVH
`define WEIGHTED_SAMPLE_SELECTOR_CORE_ASSERT_SVH
// Check an implication on every clock edge outside reset.
`define WSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check an implication in the following cycle.
`define WSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> src/wss_pkg.sv
// ----------------------------------------------------------------------------
// wss_pkg
// Shared types and opcodes of the weighted sample selector.
// ----------------------------------------------------------------------------
package wss_pkg;
    localparam int SUM_W = 24;
    localparam int OP_W  = 2;
    localparam int IDX_W = 8;
    localparam int LAB_W = 4;
    localparam int IN_W  = 16;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_EMPTY = 2'd1,
        OP_DRAW  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    // Request handed from the front part to the back part.
    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
        logic [LAB_W-1:0] lab;
        logic [IN_W-1:0]  weight;
        logic [IN_W-1:0]  frac;
    } t_req;
endpackage

>>> src/weighted_sample_selector_core.sv
// Weighted sample selector (roulette wheel over a slot table).
// Input channel: i_valid/o_ready with opcode, slot index, label, weight and
// random fraction. Output channel: o_valid/i_ready, one result per request.
// Opcode 0 writes a slot, 1 empties it, 2 draws a slot; 3 is a no-op.
// Config: i_cfg_we loads slot_count (scan length) from i_cfg_data.
// A write, empty or no-op passes S_RDOLD, S_UPD and S_OUT once taken.
// A draw passes S_RDOLD and S_DRAW, then S_RD and S_EVAL per scan step, and
// then S_OUT; a step tests one slot from each end, so a full 256-slot table
// needs up to 128 steps. The step rate is set by the registered read of the
// slot memory. The back part takes the next request in the cycle after a
// result is accepted, so it works on one request at a time.
// A two-entry queue holds requests while the back part is busy.
// Reset clears occupancy, totals and class sums; slot contents stay unknown.
// When the receiver stalls, the result holds and the back part waits; the
// queue keeps accepting until full.
// ----------------------------------------------------------------------------
// weighted_sample_selector_core
// Top level: front part, request queue and back part.
// ----------------------------------------------------------------------------
module weighted_sample_selector_core #(
    parameter int SLOTS       = 256,
    parameter int LABELS      = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_slot_index,
    input  logic [3:0]  i_entry_label,
    input  logic [15:0] i_entry_weight,
    input  logic [15:0] i_random_fraction,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_found,
    output logic [7:0]  o_chosen_slot,
    output logic [3:0]  o_chosen_label,
    output logic [23:0] o_total_weight,
    output logic [23:0] o_class_weight
);
    import wss_pkg::*;

    logic [8:0] r_cnt;
    t_req       w_push_req, w_pop_req;
    logic       w_push, w_pop, w_full, w_empty;

    // Hold the slot count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 9'd256;
        end else if (i_cfg_we) begin
            r_cnt <= i_cfg_data;
        end
    end

    wss_front #(.WEIGHT_BITS(WEIGHT_BITS)) u_front (
        .i_valid(i_valid), .o_ready(o_ready), .i_opcode(i_opcode),
        .i_slot_index(i_slot_index), .i_entry_label(i_entry_label),
        .i_entry_weight(i_entry_weight), .i_random_fraction(i_random_fraction),
        .i_q_full(w_full), .o_push(w_push), .o_req(w_push_req)
    );

    wss_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_data(w_push_req),
        .o_full(w_full), .i_pop(w_pop), .o_empty(w_empty), .o_data(w_pop_req)
    );

    wss_back #(.SLOTS(SLOTS), .LABELS(LABELS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_slot_count(r_cnt),
        .i_q_empty(w_empty), .i_req(w_pop_req), .o_pop(w_pop),
        .o_valid(o_valid), .i_ready(i_ready), .o_found(o_found),
        .o_chosen_slot(o_chosen_slot), .o_chosen_label(o_chosen_label),
        .o_total_weight(o_total_weight), .o_class_weight(o_class_weight)
    );
endmodule

>>> src/wss_queue.sv
// ----------------------------------------------------------------------------
// wss_queue
// Two-entry request queue between the front and back parts.
// ----------------------------------------------------------------------------
module wss_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wss_pkg::t_req i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output wss_pkg::t_req o_data
);
    import wss_pkg::*;

    t_req       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    // Store pushed requests.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

>>> src/wss_front.sv
// ----------------------------------------------------------------------------
// wss_front
// Accepts requests, masks weights, pushes queue.
// ----------------------------------------------------------------------------
module wss_front #(
    parameter int WEIGHT_BITS = 16
) (
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_opcode,
    input  logic [7:0]             i_slot_index,
    input  logic [3:0]             i_entry_label,
    input  logic [15:0]            i_entry_weight,
    input  logic [15:0]            i_random_fraction,
    input  logic                   i_q_full,
    output logic                   o_push,
    output wss_pkg::t_req          o_req
);
    import wss_pkg::*;

    localparam int WB = (WEIGHT_BITS < IN_W) ? WEIGHT_BITS : IN_W;
    localparam logic [IN_W-1:0] WMASK = IN_W'((64'd1 << WB) - 64'd1);

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // Build the queued request.
    always_comb begin
        o_req.op     = t_op'(i_opcode);
        o_req.idx    = i_slot_index;
        o_req.lab    = i_entry_label;
        o_req.weight = i_entry_weight & WMASK;
        o_req.frac   = i_random_fraction;
    end
endmodule

>>> src/wss_back.sv
// ----------------------------------------------------------------------------
// wss_back
// Executes requests: table updates, class sums and the two-ended draw scan.
// ----------------------------------------------------------------------------
module wss_back #(
    parameter int SLOTS       = 256,
    parameter int LABELS      = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [8:0]    i_slot_count,
    input  logic          i_q_empty,
    input  wss_pkg::t_req i_req,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic          o_found,
    output logic [7:0]    o_chosen_slot,
    output logic [3:0]    o_chosen_label,
    output logic [23:0]   o_total_weight,
    output logic [23:0]   o_class_weight
);
    import wss_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW = (LABELS > 1) ? $clog2(LABELS) : 1;
    localparam int CW = SW + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_RDOLD, S_UPD, S_DRAW, S_RD, S_EVAL, S_OUT
    } t_state;

    // Slot memory: weight and label, two read ports, one per scan end.
    logic [IN_W-1:0]  r_wmem [SLOTS];
    logic [LAB_W-1:0] r_lmem [SLOTS];
    logic [SLOTS-1:0] r_occ;
    logic [SUM_W-1:0] r_cls [LABELS];
    logic [SUM_W-1:0] r_total;

    t_state           r_state;
    t_req             r_req;
    logic [SW-1:0]    r_ra, r_rb;
    logic [IN_W-1:0]  r_wa, r_wb;
    logic [LAB_W-1:0] r_la, r_lb;
    logic [CW-1:0]    r_i, r_j;
    logic [SUM_W:0]   r_s1, r_s2;
    logic [SUM_W:0]   r_thr;
    logic [SUM_W+IN_W-1:0] n_prod;
    logic [CW-1:0]    n_m;

    logic              w_slot_ok, w_lab_ok;
    logic [LW-1:0]     w_lab, w_olab;
    logic [SW-1:0]     w_idx;

    assign w_idx     = SW'(r_req.idx);
    assign w_lab     = LW'(r_req.lab);
    assign w_olab    = LW'(r_la);
    assign w_slot_ok = (32'(r_req.idx) < SLOTS);
    assign w_lab_ok  = (32'(r_req.lab) < LABELS);
    assign n_prod    = r_req.frac * r_total;
    assign n_m       = (32'(i_slot_count) < SLOTS) ? CW'(i_slot_count) : CW'(SLOTS);
    assign o_pop     = (r_state == S_IDLE) && !i_q_empty && !o_valid;

    // Memory read ports, registered.
    always_ff @(posedge i_clk) begin
        r_wa <= r_wmem[r_ra];
        r_la <= r_lmem[r_ra];
        r_wb <= r_wmem[r_rb];
        r_lb <= r_lmem[r_rb];
        if (r_state == S_UPD && r_req.op == OP_WRITE && w_slot_ok && w_lab_ok) begin
            r_wmem[w_idx] <= r_req.weight;
            r_lmem[w_idx] <= r_req.lab;
        end
    end

    // Sequence each request and hold the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_total <= '0;
            o_valid <= 1'b0;
            for (int k = 0; k < LABELS; k++) begin
                r_cls[k] <= '0;
            end
        end else begin
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_req          <= i_req;
                        r_ra           <= SW'(i_req.idx);
                        o_found        <= 1'b0;
                        o_chosen_slot  <= '0;
                        o_chosen_label <= '0;
                        r_state        <= S_RDOLD;
                    end
                end
                S_RDOLD: begin
                    r_state <= (r_req.op == OP_DRAW) ? S_DRAW : S_UPD;
                end
                S_UPD: begin
                    // Drop old contents, then add the new entry.
                    if (w_slot_ok && (r_req.op == OP_EMPTY ||
                        (r_req.op == OP_WRITE && w_lab_ok))) begin
                        if (r_occ[w_idx]) begin
                            if (r_req.op == OP_WRITE && w_olab == w_lab) begin
                                r_cls[w_olab] <= r_cls[w_olab] - SUM_W'(r_wa)
                                                + SUM_W'(r_req.weight);
                            end else begin
                                r_cls[w_olab] <= r_cls[w_olab] - SUM_W'(r_wa);
                                if (r_req.op == OP_WRITE) begin
                                    r_cls[w_lab] <= r_cls[w_lab] + SUM_W'(r_req.weight);
                                end
                            end
                        end else if (r_req.op == OP_WRITE) begin
                            r_cls[w_lab] <= r_cls[w_lab] + SUM_W'(r_req.weight);
                        end
                        r_total <= r_total - (r_occ[w_idx] ? SUM_W'(r_wa) : '0)
                                   + ((r_req.op == OP_WRITE) ? SUM_W'(r_req.weight) : '0);
                        r_occ[w_idx] <= (r_req.op == OP_WRITE);
                    end
                    r_state <= S_OUT;
                end
                S_DRAW: begin
                    r_thr   <= {1'b0, n_prod[SUM_W+IN_W-1:IN_W]};
                    r_s1    <= '0;
                    r_s2    <= {1'b0, r_total};
                    r_i     <= '0;
                    r_j     <= n_m - CW'(1);
                    r_ra    <= '0;
                    r_rb    <= SW'(n_m - CW'(1));
                    r_state <= (n_m != '0) ? S_RD : S_OUT;
                end
                S_RD: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    // Test front slot, then back slot, then step inward.
                    if (r_occ[r_i[SW-1:0]] && (r_s1 + (SUM_W+1)'(r_wa) >= r_thr)) begin
                        o_found        <= 1'b1;
                        o_chosen_slot  <= 8'(r_i);
                        o_chosen_label <= r_la;
                        r_state        <= S_OUT;
                    end else if (r_occ[r_j[SW-1:0]] &&
                                 ($signed(r_s2 - (SUM_W+1)'(r_wb)) <= $signed(r_thr))) begin
                        o_found        <= 1'b1;
                        o_chosen_slot  <= 8'(r_j);
                        o_chosen_label <= r_lb;
                        r_state        <= S_OUT;
                    end else begin
                        if (r_occ[r_i[SW-1:0]]) begin
                            r_s1 <= r_s1 + (SUM_W+1)'(r_wa);
                        end
                        if (r_occ[r_j[SW-1:0]]) begin
                            r_s2 <= r_s2 - (SUM_W+1)'(r_wb);
                        end
                        if (r_i + CW'(1) > r_j - CW'(1) || r_j == '0) begin
                            r_state <= S_OUT;
                        end else begin
                            r_i     <= r_i + CW'(1);
                            r_j     <= r_j - CW'(1);
                            r_ra    <= SW'(r_i + CW'(1));
                            r_rb    <= SW'(r_j - CW'(1));
                            r_state <= S_RD;
                        end
                    end
                end
                S_OUT: begin
                    o_total_weight <= r_total;
                    o_class_weight <= w_lab_ok ? r_cls[w_lab] : '0;
                    o_valid        <= 1'b1;
                    r_state        <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> src/wss_checker.sv
// ----------------------------------------------------------------------------
// wss_checker
// Port-level checks of the selector, bound to the top level.
// ----------------------------------------------------------------------------
`include "weighted_sample_selector_core_assert.svh"
module wss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_found,
    input logic [7:0]  o_chosen_slot,
    input logic [3:0]  o_chosen_label,
    input logic [23:0] o_total_weight,
    input logic [23:0] o_class_weight
);
    logic [60:0] w_res;

    // Gather the result payload.
    assign w_res = {o_found, o_chosen_slot, o_chosen_label, o_total_weight, o_class_weight};

    `WSS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `WSS_ASSERT_NEXT(a_keep, i_clk, i_rst_n, o_valid && !i_ready, $stable(w_res))
    `WSS_ASSERT_IMPL(a_nf_slot, i_clk, i_rst_n, o_valid && !o_found, o_chosen_slot == 8'd0)
    `WSS_ASSERT_IMPL(a_nf_lab, i_clk, i_rst_n, o_valid && !o_found, o_chosen_label == 4'd0)
endmodule

bind weighted_sample_selector_core wss_checker u_chk (.*);

>>> sim/weighted_sample_selector_core_checker.sv
// ----------------------------------------------------------------------------
// Weighted sample selector checker
// Watches the request, result and configuration ports, keeps its own copy of
// the slot table, sums and scan length, predicts the result of every accepted
// request and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module weighted_sample_selector_core_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_data,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_slot_index,
    input  logic [3:0]  i_entry_label,
    input  logic [15:0] i_entry_weight,
    input  logic [15:0] i_random_fraction,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_found,
    input  logic [7:0]  i_chosen_slot,
    input  logic [3:0]  i_chosen_label,
    input  logic [23:0] i_total_weight,
    input  logic [23:0] i_class_weight,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import wss_pkg::*;

    typedef struct packed {
        logic        found;
        logic [7:0]  slot;
        logic [3:0]  label;
        logic [23:0] total;
        logic [23:0] class_sum;
    } t_outcome;

    logic [15:0]       slot_weight [256];
    logic [3:0]        slot_label  [256];
    logic [255:0]      slot_used;
    logic [SUM_W-1:0]  label_sum   [16];
    logic [SUM_W-1:0]  table_total;
    logic [8:0]        scan_len;
    t_outcome          expected_q [$];

    assign o_pending = expected_q.size();

    // Take an occupied slot off the totals.
    function automatic void release_slot(input int s);
        if (slot_used[s]) begin
            table_total = table_total - 24'(slot_weight[s]);
            label_sum[slot_label[s]] = label_sum[slot_label[s]] - 24'(slot_weight[s]);
            slot_used[s] = 1'b0;
        end
    endfunction

    // Apply one request to the table and return the result it should give.
    function automatic t_outcome apply_request(input t_op op, input logic [7:0] idx,
                                               input logic [3:0] lab,
                                               input logic [15:0] w,
                                               input logic [15:0] frac);
        t_outcome res;
        longint thresh, front_sum, back_sum;
        int span, i, j;
        res = '0;
        case (op)
            OP_WRITE: begin
                release_slot(idx);
                slot_weight[idx] = w;
                slot_label[idx]  = lab;
                slot_used[idx]   = 1'b1;
                table_total = table_total + 24'(w);
                label_sum[lab] = label_sum[lab] + 24'(w);
            end
            OP_EMPTY: release_slot(idx);
            OP_DRAW: begin
                thresh    = (longint'(frac) * longint'(table_total)) >>> 16;
                span      = (scan_len < 256) ? int'(scan_len) : 256;
                front_sum = 0;
                back_sum  = longint'(table_total);
                i = 0;
                j = span - 1;
                // Scan inward from both ends, front slot first.
                while (i <= j && !res.found) begin
                    if (slot_used[i]) begin
                        front_sum += longint'(slot_weight[i]);
                        if (front_sum >= thresh) begin
                            res.found = 1'b1;
                            res.slot  = 8'(i);
                        end
                    end
                    if (!res.found && slot_used[j]) begin
                        back_sum -= longint'(slot_weight[j]);
                        if (back_sum <= thresh) begin
                            res.found = 1'b1;
                            res.slot  = 8'(j);
                        end
                    end
                    i++;
                    j--;
                end
                if (res.found) res.label = slot_label[res.slot];
            end
            default: ;
        endcase
        res.total     = table_total;
        res.class_sum = label_sum[lab];
        return res;
    endfunction

    // Track configuration, predict on each request, compare on each result.
    always @(posedge i_clk) begin
        t_outcome got, want;
        if (!i_rst_n) begin
            slot_used   <= '0;
            table_total <= '0;
            scan_len    <= 9'd256;
            for (int k = 0; k < 16; k++) label_sum[k] <= '0;
            expected_q.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) scan_len <= i_cfg_data;
            if (i_valid && i_ready_in) begin
                want = apply_request(t_op'(i_opcode), i_slot_index, i_entry_label,
                                     i_entry_weight, i_random_fraction);
                expected_q.insert(expected_q.size(), want);
            end
            if (i_out_valid && i_out_ready) begin
                got = {i_found, i_chosen_slot, i_chosen_label, i_total_weight,
                       i_class_weight};
                if (expected_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("%0t: result with nothing expected: %p", $realtime, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        if (o_errors < 10) begin
                            $display("%0t: mismatch exp found=%0d slot=%0d label=%0d %s",
                                     $realtime, want.found, want.slot, want.label,
                                     $sformatf("total=%0d class=%0d", want.total,
                                               want.class_sum));
                            $display("%0t:          got found=%0d slot=%0d label=%0d %s",
                                     $realtime, got.found, got.slot, got.label,
                                     $sformatf("total=%0d class=%0d", got.total,
                                               got.class_sum));
                        end
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

>>> sim/weighted_sample_selector_core_tb.sv
// ----------------------------------------------------------------------------
// Weighted sample selector testbench
// Drives directed and random slot writes, empties, draws and no-ops through
// the request channel under several scan lengths and stall patterns; the
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module weighted_sample_selector_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wss_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [8:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_opcode = '0;
    logic [7:0]  i_slot_index = '0;
    logic [3:0]  i_entry_label = '0;
    logic [15:0] i_entry_weight = '0;
    logic [15:0] i_random_fraction = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_found;
    logic [7:0]  o_chosen_slot;
    logic [3:0]  o_chosen_label;
    logic [23:0] o_total_weight;
    logic [23:0] o_class_weight;

    int errors, pending;
    int send_idle_pct = 0, recv_idle_pct = 0;
    int cycles = 0, n_requests = 0, n_draws = 0;

    weighted_sample_selector_core u_dut (.*);

    weighted_sample_selector_core_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data,
        .i_valid, .i_ready_in(o_ready), .i_opcode, .i_slot_index, .i_entry_label,
        .i_entry_weight, .i_random_fraction,
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_found(o_found),
        .i_chosen_slot(o_chosen_slot), .i_chosen_label(o_chosen_label),
        .i_total_weight(o_total_weight), .i_class_weight(o_class_weight),
        .o_errors(errors), .o_pending(pending)
    );

    always #6 i_clk = ~i_clk;

    // Stall the result channel at random; give up at the cycle limit.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
        cycles  <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offer one request, sometimes after a random gap, and hold it until accepted.
    task automatic send(input t_op op, input logic [7:0] idx, input logic [3:0] lab,
                        input logic [15:0] w, input logic [15:0] frac);
        int gap;
        logic taken;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_opcode          <= op;
        i_slot_index      <= idx;
        i_entry_label     <= lab;
        i_entry_weight    <= w;
        i_random_fraction <= frac;
        do begin
            @(negedge i_clk);
            taken = o_ready;
            @(posedge i_clk);
        end while (!taken);
        n_requests++;
        if (op == OP_DRAW) n_draws++;
    endtask

    // Drop valid and wait for every outstanding result.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_scan_len(input logic [8:0] len);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= len;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Random request: mostly writes and draws on a table kept near the scan range.
    task automatic send_random(input int hi_slot);
        int pick;
        t_op op;
        logic [7:0] idx;
        logic [15:0] w;
        pick = $urandom_range(99);
        op   = (pick < 40) ? OP_WRITE : (pick < 55) ? OP_EMPTY :
               (pick < 93) ? OP_DRAW : OP_NOP;
        idx  = ($urandom_range(99) < 80) ? 8'($urandom_range(hi_slot)) : 8'($urandom);
        w    = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(300));
        send(op, idx, 4'($urandom), w, 16'($urandom));
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every opcode, empty table, repeated empty.
        set_scan_len(9'd256);
        send(OP_DRAW,  8'd0,   4'd0,  16'd0,     16'hFFFF);
        send(OP_WRITE, 8'd0,   4'd0,  16'hFFFF,  16'd0);
        send(OP_WRITE, 8'd255, 4'd15, 16'hFFFF,  16'd0);
        send(OP_WRITE, 8'd128, 4'd7,  16'd0,     16'd0);
        send(OP_DRAW,  8'd0,   4'd15, 16'd0,     16'd0);
        send(OP_DRAW,  8'd0,   4'd0,  16'd0,     16'hFFFF);
        send(OP_DRAW,  8'd0,   4'd7,  16'd0,     16'h8000);
        send(OP_WRITE, 8'd0,   4'd15, 16'd5,     16'd0);
        send(OP_EMPTY, 8'd255, 4'd15, 16'd0,     16'd0);
        send(OP_EMPTY, 8'd255, 4'd15, 16'd0,     16'd0);
        send(OP_NOP,   8'hAA,  4'd5,  16'h5A5A,  16'hA5A5);
        send(OP_DRAW,  8'd0,   4'd0,  16'd0,     16'hFFFF);
        send(OP_WRITE, 8'd200, 4'd3,  16'd1000,  16'd0);
        drain();
        set_scan_len(9'd1);
        send(OP_DRAW,  8'd0,   4'd3,  16'd0,     16'hFFFF);
        set_scan_len(9'd0);
        send(OP_DRAW,  8'd0,   4'd3,  16'd0,     16'h1234);
        set_scan_len(9'd511);
        send(OP_DRAW,  8'd0,   4'd3,  16'd0,     16'hFFFF);
        send(OP_EMPTY, 8'd0,   4'd0,  16'd0,     16'd0);
        send(OP_DRAW,  8'd0,   4'd0,  16'd0,     16'd1);

        // Random phases with changing scan length and stall pattern.
        send_idle_pct = 32; recv_idle_pct = 54;
        set_scan_len(9'd256);
        for (int k = 0; k < 320; k++) send_random(255);
        send_idle_pct = 54; recv_idle_pct = 32;
        set_scan_len(9'd40);
        for (int k = 0; k < 320; k++) send_random(50);
        send_idle_pct = 0; recv_idle_pct = 0;
        set_scan_len(9'd300);
        for (int k = 0; k < 310; k++) send_random(255);

        drain();
        repeat (300) @(posedge i_clk);
        $display("Covered %0d requests (%0d draws) over scan lengths 0, 1, 40, 256, 300, 511",
                 n_requests, n_draws);
        $display("with sender and receiver stalls swapped between phases.");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+src
src/wss_pkg.sv
src/wss_queue.sv
src/wss_front.sv
src/wss_back.sv
src/weighted_sample_selector_core.sv
src/wss_checker.sv
sim/weighted_sample_selector_core_checker.sv
sim/weighted_sample_selector_core_tb.sv
